// ===== rtl/core/a32dec_pkg.sv =====
// Package: class codes, flag bits and the decoded record type for the ARM decoder.
`timescale 1ns / 1ps
package a32dec_pkg;

    typedef enum logic [5:0] {
        CL_B       = 6'd0,
        CL_BL      = 6'd1,
        CL_BLX     = 6'd2,
        CL_ALU     = 6'd3,
        CL_LDR     = 6'd19,
        CL_STR     = 6'd20,
        CL_LDRB    = 6'd21,
        CL_STRB    = 6'd22,
        CL_LDRH    = 6'd23,
        CL_STRH    = 6'd24,
        CL_LDRSB   = 6'd25,
        CL_LDRSH   = 6'd26,
        CL_LDM     = 6'd27,
        CL_STM     = 6'd28,
        CL_PUSH    = 6'd29,
        CL_POP     = 6'd30,
        CL_MUL     = 6'd31,
        CL_MLA     = 6'd32,
        CL_UMULL   = 6'd33,
        CL_UMLAL   = 6'd34,
        CL_SMULL   = 6'd35,
        CL_SMLAL   = 6'd36,
        CL_BX      = 6'd37,
        CL_CLZ     = 6'd38,
        CL_SWI     = 6'd39,
        CL_BKPT    = 6'd40,
        CL_MRS     = 6'd41,
        CL_MSR     = 6'd42,
        CL_MRC     = 6'd43,
        CL_MCR     = 6'd44,
        CL_UNKNOWN = 6'd46
    } cls_t;

    localparam logic [4:0] FF_BRANCH   = 5'd1;
    localparam logic [4:0] FF_CALL     = 5'd2;
    localparam logic [4:0] FF_RETURN   = 5'd4;
    localparam logic [4:0] FF_INDIRECT = 5'd8;
    localparam logic [4:0] FF_CONDBR   = 5'd16;

    localparam logic [7:0] MF_PRE    = 8'd1;
    localparam logic [7:0] MF_ADD    = 8'd2;
    localparam logic [7:0] MF_WB     = 8'd4;
    localparam logic [7:0] MF_S      = 8'd8;
    localparam logic [7:0] MF_IMM    = 8'd16;
    localparam logic [7:0] MF_RSHIFT = 8'd32;
    localparam logic [7:0] MF_ISHIFT = 8'd64;
    localparam logic [7:0] MF_SPSR   = 8'd128;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;
    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    localparam logic [3:0] OP_MOV = 4'hD;

    typedef struct packed {
        logic [5:0]  cls;
        logic [3:0]  cond;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [3:0]  rs;
        logic [31:0] imm;
        logic [31:0] target;
        logic [4:0]  flow;
        logic [7:0]  mode;
        logic [6:0]  shift;
        logic [19:0] extra;
    } rec_t;

    function automatic logic [31:0] rot_imm(input logic [31:0] w);
        logic [4:0]  r;
        logic [63:0] d;
        r = {w[11:8], 1'b0};
        d = {24'd0, w[7:0], 24'd0, w[7:0]} >> r;
        return d[31:0];
    endfunction

endpackage

// ===== rtl/core/a32dec_logic.sv =====
// Combinational decode of one instruction word into a decoded record.
`timescale 1ns / 1ps
module a32dec_logic
(
    input  logic [31:0]       w,
    input  logic [31:0]       addr,
    output a32dec_pkg::rec_t  rec
);

    logic is_msr_reg;
    logic is_msr_imm;
    logic [31:0] boff;
    logic [11:0] hoff;

    assign is_msr_reg = (w & 32'h0FB0F000) == 32'h0120F000;
    assign is_msr_imm = (w & 32'h0FB0F000) == 32'h0320F000;
    assign boff = {{6{w[23]}}, w[23:0], 2'b00};
    assign hoff = {4'd0, w[11:8], w[3:0]};

    always_comb
    begin
        logic misc;
        logic pre;
        logic [3:0] op;
        logic has_rd;
        rec = '0;
        rec.cond = w[31:28];
        pre = w[24];
        op = w[24:21];
        has_rd = 1'b0;
        misc = 1'b0;
        if ((w & 32'hFE000000) == 32'hFA000000 || (w & 32'h0E000000) == 32'h0A000000)
        begin
            rec.imm = boff;
            rec.mode = a32dec_pkg::MF_IMM;
            rec.flow = a32dec_pkg::FF_BRANCH;
            rec.target = addr + 32'd8 + boff;
            if (w[31:28] == a32dec_pkg::COND_NV)
            begin
                rec.cls = a32dec_pkg::CL_BLX;
                rec.flow = rec.flow | a32dec_pkg::FF_CALL;
                rec.target = addr + 32'd8 + (boff | {30'd0, w[24], 1'b0});
            end
            else if (w[24])
            begin
                rec.cls = a32dec_pkg::CL_BL;
                rec.flow = rec.flow | a32dec_pkg::FF_CALL;
            end
            else
            begin
                rec.cls = a32dec_pkg::CL_B;
                if (w[31:28] != a32dec_pkg::COND_AL)
                    rec.flow = rec.flow | a32dec_pkg::FF_CONDBR;
            end
        end
        else if ((w & 32'h0E000000) == 32'h08000000)
        begin
            rec.rn = w[19:16];
            rec.extra = {4'd0, w[15:0]};
            rec.mode = (w[24] ? a32dec_pkg::MF_PRE : 8'd0) | (w[23] ? a32dec_pkg::MF_ADD : 8'd0)
                     | (w[21] ? a32dec_pkg::MF_WB : 8'd0) | (w[22] ? a32dec_pkg::MF_S : 8'd0);
            if (w[19:16] == a32dec_pkg::REG_SP && w[20] && !w[24] && w[23] && w[21])
                rec.cls = a32dec_pkg::CL_POP;
            else if (w[19:16] == a32dec_pkg::REG_SP && !w[20] && w[24] && !w[23] && w[21])
                rec.cls = a32dec_pkg::CL_PUSH;
            else
                rec.cls = w[20] ? a32dec_pkg::CL_LDM : a32dec_pkg::CL_STM;
            if (w[20] && w[15])
                rec.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_RETURN;
        end
        else if ((w & 32'h0C000000) == 32'h04000000)
        begin
            rec.rn = w[19:16];
            rec.rd = w[15:12];
            rec.mode = (pre ? a32dec_pkg::MF_PRE : 8'd0) | (w[23] ? a32dec_pkg::MF_ADD : 8'd0)
                     | ((!pre || w[21]) ? a32dec_pkg::MF_WB : 8'd0);
            rec.cls = w[20] ? (w[22] ? a32dec_pkg::CL_LDRB : a32dec_pkg::CL_LDR)
                            : (w[22] ? a32dec_pkg::CL_STRB : a32dec_pkg::CL_STR);
            if (!w[25])
            begin
                rec.imm = w[23] ? {20'd0, w[11:0]} : 32'd0 - {20'd0, w[11:0]};
                rec.mode = rec.mode | a32dec_pkg::MF_IMM;
            end
            else
            begin
                rec.rm = w[3:0];
                rec.shift = {w[11:7], w[6:5]};
            end
            if (w[20] && w[15:12] == a32dec_pkg::REG_PC)
                rec.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_INDIRECT;
        end
        else if ((w & 32'h0E000090) == 32'h00000090 && w[6:5] != 2'd0)
        begin
            rec.rn = w[19:16];
            rec.rd = w[15:12];
            rec.mode = (pre ? a32dec_pkg::MF_PRE : 8'd0) | (w[23] ? a32dec_pkg::MF_ADD : 8'd0)
                     | ((!pre || w[21]) ? a32dec_pkg::MF_WB : 8'd0);
            if (w[20])
                rec.cls = (w[6:5] == 2'd2) ? a32dec_pkg::CL_LDRSB
                        : (w[6:5] == 2'd3) ? a32dec_pkg::CL_LDRSH : a32dec_pkg::CL_LDRH;
            else
                rec.cls = a32dec_pkg::CL_STRH;
            if (w[22])
            begin
                rec.imm = w[23] ? {20'd0, hoff} : 32'd0 - {20'd0, hoff};
                rec.mode = rec.mode | a32dec_pkg::MF_IMM;
            end
            else
                rec.rm = w[3:0];
        end
        else if ((w & 32'h0F0000F0) == 32'h00000090)
        begin
            if (w[20])
                rec.mode = a32dec_pkg::MF_S;
            rec.rd = w[19:16];
            rec.rn = w[15:12];
            rec.rs = w[11:8];
            rec.rm = w[3:0];
            if (w[23])
            begin
                if (w[22])
                    rec.cls = w[21] ? a32dec_pkg::CL_SMLAL : a32dec_pkg::CL_SMULL;
                else
                    rec.cls = w[21] ? a32dec_pkg::CL_UMLAL : a32dec_pkg::CL_UMULL;
            end
            else
                rec.cls = w[21] ? a32dec_pkg::CL_MLA : a32dec_pkg::CL_MUL;
        end
        else if ((w & 32'h0F000000) == 32'h0F000000 || (w & 32'h0FBF0000) == 32'h010F0000
                 || is_msr_reg || is_msr_imm
                 || (w & 32'h0FFFFFF0) == 32'h012FFF10 || (w & 32'h0FFFFFF0) == 32'h012FFF30
                 || (w & 32'h0FFF0FF0) == 32'h016F0F10 || (w & 32'h0FF000F0) == 32'h01200070)
            misc = 1'b1;
        else if (w[27:26] == 2'd0)
        begin
            has_rd = (op < 4'd8) || (op > 4'd11);
            rec.cls = a32dec_pkg::CL_ALU + {2'd0, op};
            rec.rn = w[19:16];
            rec.rd = w[15:12];
            if (w[20])
                rec.mode = a32dec_pkg::MF_S;
            if (w[25])
            begin
                rec.imm = a32dec_pkg::rot_imm(w);
                rec.mode = rec.mode | a32dec_pkg::MF_IMM;
            end
            else
            begin
                rec.rm = w[3:0];
                if (w[4])
                begin
                    rec.mode = rec.mode | a32dec_pkg::MF_RSHIFT;
                    rec.rs = w[11:8];
                    rec.shift = {5'd0, w[6:5]};
                end
                else
                begin
                    rec.shift = {w[11:7], w[6:5]};
                    if (w[11:5] != 7'd0)
                        rec.mode = rec.mode | a32dec_pkg::MF_ISHIFT;
                end
            end
            if (has_rd && w[15:12] == a32dec_pkg::REG_PC)
            begin
                if (op == a32dec_pkg::OP_MOV && rec.rm == a32dec_pkg::REG_LR)
                    rec.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_RETURN;
                else
                    rec.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_INDIRECT;
            end
        end
        else
            misc = 1'b1;

        if (misc)
        begin
            if ((w & 32'h0FFFFFF0) == 32'h012FFF10)
            begin
                rec.cls = a32dec_pkg::CL_BX;
                rec.rm = w[3:0];
                rec.flow = a32dec_pkg::FF_BRANCH | ((w[3:0] == a32dec_pkg::REG_LR)
                         ? a32dec_pkg::FF_RETURN : a32dec_pkg::FF_INDIRECT);
            end
            else if ((w & 32'h0FFFFFF0) == 32'h012FFF30)
            begin
                rec.cls = a32dec_pkg::CL_BLX;
                rec.rm = w[3:0];
                rec.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_CALL | a32dec_pkg::FF_INDIRECT;
            end
            else if ((w & 32'h0FFF0FF0) == 32'h016F0F10)
            begin
                rec.cls = a32dec_pkg::CL_CLZ;
                rec.rd = w[15:12];
                rec.rm = w[3:0];
            end
            else if ((w & 32'h0F000000) == 32'h0F000000)
            begin
                rec.cls = a32dec_pkg::CL_SWI;
                rec.imm = {8'd0, w[23:0]};
                rec.mode = a32dec_pkg::MF_IMM;
            end
            else if ((w & 32'hFFF000F0) == 32'hE1200070)
            begin
                rec.cls = a32dec_pkg::CL_BKPT;
                rec.imm = {16'd0, w[23:12], w[3:0]};
                rec.mode = a32dec_pkg::MF_IMM;
            end
            else if ((w & 32'h0FBF0FFF) == 32'h010F0000)
            begin
                rec.cls = a32dec_pkg::CL_MRS;
                rec.rd = w[15:12];
                rec.mode = w[22] ? a32dec_pkg::MF_SPSR : 8'd0;
            end
            else if (is_msr_reg)
            begin
                rec.cls = a32dec_pkg::CL_MSR;
                rec.rm = w[3:0];
                rec.mode = w[22] ? a32dec_pkg::MF_SPSR : 8'd0;
                rec.extra = {16'd0, w[19:16]};
            end
            else if (is_msr_imm)
            begin
                rec.cls = a32dec_pkg::CL_MSR;
                rec.imm = a32dec_pkg::rot_imm(w);
                rec.mode = (w[22] ? a32dec_pkg::MF_SPSR : 8'd0) | a32dec_pkg::MF_IMM;
                rec.extra = {16'd0, w[19:16]};
            end
            else if ((w & 32'h0F000010) == 32'h0E000010)
            begin
                rec.cls = w[20] ? a32dec_pkg::CL_MRC : a32dec_pkg::CL_MCR;
                rec.rd = w[15:12];
                rec.extra = {2'd0, w[11:8], w[23:21], w[7:5], w[19:16], w[3:0]};
            end
            else
                rec.cls = a32dec_pkg::CL_UNKNOWN;
        end
    end

endmodule

// ===== rtl/core/arm32_instruction_decoder.sv =====
// Top level: input register, decode logic and result register with valid/ready.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | instr_word, instr_address
//  out     | output    | out_valid / out_ready | instr_class .. extra_bundle
//
// One transaction per cycle sustained while out_ready does not stall the result register.
// The input register and result register form a two-stage pipeline with a
// full-pipeline stall: both advance whenever the result register is empty or taken.
// Reset clears both valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module arm32_instruction_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        instr_word,
    input  logic [31:0]        instr_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         instr_class,
    output logic [3:0]         cond_code,
    output logic [3:0]         dest_reg,
    output logic [3:0]         base_reg,
    output logic [3:0]         operand_reg,
    output logic [3:0]         second_reg,
    output logic signed [31:0] imm_value,
    output logic [31:0]        jump_target,
    output logic [4:0]         flow_flags,
    output logic [7:0]         mode_flags,
    output logic [6:0]         shift_info,
    output logic [19:0]        extra_bundle
);

    logic              s1_valid_reg;
    logic [31:0]       word_reg;
    logic [31:0]       addr_reg;
    logic              s2_valid_reg;
    a32dec_pkg::rec_t  rec_reg;
    a32dec_pkg::rec_t  rec_next;
    logic              adv;

    assign adv = !s2_valid_reg || out_ready;
    assign in_ready = adv;

    a32dec_logic u_logic
    (
        .w    (word_reg),
        .addr (addr_reg),
        .rec  (rec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_valid)
            begin
                word_reg <= instr_word;
                addr_reg <= instr_address;
            end
            if (s1_valid_reg)
                rec_reg <= rec_next;
        end
    end

    assign out_valid     = s2_valid_reg;
    assign instr_class   = rec_reg.cls;
    assign cond_code     = rec_reg.cond;
    assign dest_reg      = rec_reg.rd;
    assign base_reg      = rec_reg.rn;
    assign operand_reg   = rec_reg.rm;
    assign second_reg    = rec_reg.rs;
    assign imm_value     = rec_reg.imm;
    assign jump_target   = rec_reg.target;
    assign flow_flags    = rec_reg.flow;
    assign mode_flags    = rec_reg.mode;
    assign shift_info    = rec_reg.shift;
    assign extra_bundle  = rec_reg.extra;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rec_reg))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg |-> in_ready)
        else $error("input blocked with empty output");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted transaction lost");

    a_cond_copied: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && adv |=> rec_reg.cond == $past(word_reg[31:28]))
        else $error("condition field mismatch");

endmodule

// ===== test/arm32_instruction_decoder_tb.sv =====
// Testbench for the ARM instruction decoder: random and directed words checked against a predictor.
`timescale 1ns / 1ps
module arm32_instruction_decoder_tb;

    class decode_scoreboard;
        a32dec_pkg::rec_t pending[$];
        int   errors;
        int   checked;

        static function logic [31:0] rotate_imm(logic [31:0] w);
            logic [63:0] d;
            d = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
            return d[31:0];
        endfunction

        static function logic msr_reg(logic [31:0] w);
            return (w & 32'h0FB0F000) == 32'h0120F000;
        endfunction

        static function logic msr_imm(logic [31:0] w);
            return (w & 32'h0FB0F000) == 32'h0320F000;
        endfunction

        static function a32dec_pkg::rec_t decode_sys_group(logic [31:0] w,
                                                           a32dec_pkg::rec_t o);
            logic [7:0] spsr;
            spsr = w[22] ? a32dec_pkg::MF_SPSR : 8'd0;
            if ((w & 32'h0FFFFFF0) == 32'h012FFF10) begin
                o.cls = a32dec_pkg::CL_BX;
                o.rm = w[3:0];
                o.flow = a32dec_pkg::FF_BRANCH | ((o.rm == a32dec_pkg::REG_LR)
                       ? a32dec_pkg::FF_RETURN : a32dec_pkg::FF_INDIRECT);
            end else if ((w & 32'h0FFFFFF0) == 32'h012FFF30) begin
                o.cls = a32dec_pkg::CL_BLX;
                o.rm = w[3:0];
                o.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_CALL | a32dec_pkg::FF_INDIRECT;
            end else if ((w & 32'h0FFF0FF0) == 32'h016F0F10) begin
                o.cls = a32dec_pkg::CL_CLZ;
                o.rd = w[15:12];
                o.rm = w[3:0];
            end else if (w[27:24] == 4'hF) begin
                o.cls = a32dec_pkg::CL_SWI;
                o.imm = {8'd0, w[23:0]};
                o.mode = a32dec_pkg::MF_IMM;
            end else if ((w & 32'hFFF000F0) == 32'hE1200070) begin
                o.cls = a32dec_pkg::CL_BKPT;
                o.imm = {16'd0, w[23:12], w[3:0]};
                o.mode = a32dec_pkg::MF_IMM;
            end else if ((w & 32'h0FBF0FFF) == 32'h010F0000) begin
                o.cls = a32dec_pkg::CL_MRS;
                o.rd = w[15:12];
                o.mode = spsr;
            end else if (msr_reg(w)) begin
                o.cls = a32dec_pkg::CL_MSR;
                o.rm = w[3:0];
                o.mode = spsr;
                o.extra = {16'd0, w[19:16]};
            end else if (msr_imm(w)) begin
                o.cls = a32dec_pkg::CL_MSR;
                o.imm = rotate_imm(w);
                o.mode = spsr | a32dec_pkg::MF_IMM;
                o.extra = {16'd0, w[19:16]};
            end else if ((w & 32'h0F000010) == 32'h0E000010) begin
                o.cls = w[20] ? a32dec_pkg::CL_MRC : a32dec_pkg::CL_MCR;
                o.rd = w[15:12];
                o.extra = {2'd0, w[11:8], w[23:21], w[7:5], w[19:16], w[3:0]};
            end else begin
                o.cls = a32dec_pkg::CL_UNKNOWN;
            end
            return o;
        endfunction

        static function a32dec_pkg::rec_t decode_word(logic [31:0] w, logic [31:0] addr);
            a32dec_pkg::rec_t o;
            logic [31:0] off;
            logic [3:0] op;
            logic [1:0] hop;
            o = '0;
            o.cond = w[31:28];
            if ((w & 32'hFE000000) == 32'hFA000000 || w[27:25] == 3'b101) begin
                off = {{6{w[23]}}, w[23:0], 2'b00};
                o.imm = off;
                o.mode = a32dec_pkg::MF_IMM;
                o.flow = a32dec_pkg::FF_BRANCH;
                o.target = addr + 32'd8 + off;
                if (o.cond == a32dec_pkg::COND_NV) begin
                    o.cls = a32dec_pkg::CL_BLX;
                    o.flow |= a32dec_pkg::FF_CALL;
                    o.target = addr + 32'd8 + (off | {30'd0, w[24], 1'b0});
                end else if (w[24]) begin
                    o.cls = a32dec_pkg::CL_BL;
                    o.flow |= a32dec_pkg::FF_CALL;
                end else begin
                    o.cls = a32dec_pkg::CL_B;
                    if (o.cond != a32dec_pkg::COND_AL) o.flow |= a32dec_pkg::FF_CONDBR;
                end
            end else if (w[27:25] == 3'b100) begin
                o.rn = w[19:16];
                o.extra = {4'd0, w[15:0]};
                o.mode = {4'd0, w[22], w[21], w[23], w[24]};
                if (o.rn == a32dec_pkg::REG_SP && w[20] && !w[24] && w[23] && w[21])
                    o.cls = a32dec_pkg::CL_POP;
                else if (o.rn == a32dec_pkg::REG_SP && !w[20] && w[24] && !w[23] && w[21])
                    o.cls = a32dec_pkg::CL_PUSH;
                else
                    o.cls = w[20] ? a32dec_pkg::CL_LDM : a32dec_pkg::CL_STM;
                if (w[20] && w[15]) o.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_RETURN;
            end else if (w[27:26] == 2'b01) begin
                o.rn = w[19:16];
                o.rd = w[15:12];
                o.mode = {5'd0, (!w[24] || w[21]), w[23], w[24]};
                o.cls = w[20] ? (w[22] ? a32dec_pkg::CL_LDRB : a32dec_pkg::CL_LDR)
                              : (w[22] ? a32dec_pkg::CL_STRB : a32dec_pkg::CL_STR);
                if (!w[25]) begin
                    o.imm = w[23] ? {20'd0, w[11:0]} : 32'd0 - {20'd0, w[11:0]};
                    o.mode |= a32dec_pkg::MF_IMM;
                end else begin
                    o.rm = w[3:0];
                    o.shift = {w[11:7], w[6:5]};
                end
                if (w[20] && o.rd == a32dec_pkg::REG_PC)
                    o.flow = a32dec_pkg::FF_BRANCH | a32dec_pkg::FF_INDIRECT;
            end else if ((w & 32'h0E000090) == 32'h00000090 && w[6:5] != 2'd0) begin
                hop = w[6:5];
                o.rn = w[19:16];
                o.rd = w[15:12];
                o.mode = {5'd0, (!w[24] || w[21]), w[23], w[24]};
                if (w[20])
                    o.cls = (hop == 2'd2) ? a32dec_pkg::CL_LDRSB
                          : (hop == 2'd3) ? a32dec_pkg::CL_LDRSH : a32dec_pkg::CL_LDRH;
                else
                    o.cls = a32dec_pkg::CL_STRH;
                if (w[22]) begin
                    o.imm = w[23] ? {24'd0, w[11:8], w[3:0]}
                                  : 32'd0 - {24'd0, w[11:8], w[3:0]};
                    o.mode |= a32dec_pkg::MF_IMM;
                end else begin
                    o.rm = w[3:0];
                end
            end else if ((w & 32'h0F0000F0) == 32'h00000090) begin
                if (w[20]) o.mode = a32dec_pkg::MF_S;
                o.rd = w[19:16];
                o.rn = w[15:12];
                o.rs = w[11:8];
                o.rm = w[3:0];
                if (w[23])
                    o.cls = w[22] ? (w[21] ? a32dec_pkg::CL_SMLAL : a32dec_pkg::CL_SMULL)
                                  : (w[21] ? a32dec_pkg::CL_UMLAL : a32dec_pkg::CL_UMULL);
                else
                    o.cls = w[21] ? a32dec_pkg::CL_MLA : a32dec_pkg::CL_MUL;
            end else if (w[27:24] == 4'hF || (w & 32'h0FBF0000) == 32'h010F0000
                         || msr_reg(w) || msr_imm(w)
                         || (w & 32'h0FFFFFF0) == 32'h012FFF10
                         || (w & 32'h0FFFFFF0) == 32'h012FFF30
                         || (w & 32'h0FFF0FF0) == 32'h016F0F10
                         || (w & 32'h0FF000F0) == 32'h01200070) begin
                o = decode_sys_group(w, o);
            end else if (w[27:26] == 2'b00) begin
                op = w[24:21];
                o.cls = a32dec_pkg::CL_ALU + {2'd0, op};
                o.rn = w[19:16];
                o.rd = w[15:12];
                if (w[20]) o.mode |= a32dec_pkg::MF_S;
                if (w[25]) begin
                    o.imm = rotate_imm(w);
                    o.mode |= a32dec_pkg::MF_IMM;
                end else begin
                    o.rm = w[3:0];
                    if (w[4]) begin
                        o.mode |= a32dec_pkg::MF_RSHIFT;
                        o.rs = w[11:8];
                        o.shift = {5'd0, w[6:5]};
                    end else begin
                        o.shift = {w[11:7], w[6:5]};
                        if (w[11:7] != 5'd0 || w[6:5] != 2'd0)
                            o.mode |= a32dec_pkg::MF_ISHIFT;
                    end
                end
                if ((op < 4'd8 || op > 4'd11) && o.rd == a32dec_pkg::REG_PC) begin
                    o.flow = a32dec_pkg::FF_BRANCH;
                    if (op == a32dec_pkg::OP_MOV && o.rm == a32dec_pkg::REG_LR)
                        o.flow |= a32dec_pkg::FF_RETURN;
                    else
                        o.flow |= a32dec_pkg::FF_INDIRECT;
                end
            end else begin
                o = decode_sys_group(w, o);
            end
            return o;
        endfunction

        function void note_word(logic [31:0] w, logic [31:0] addr);
            pending = {pending, decode_word(w, addr)};
        endfunction

        function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("mismatch %s: expected %h got %h", what, want, got);
        endfunction

        function void check_record(a32dec_pkg::rec_t got);
            a32dec_pkg::rec_t exp_rec;
            if (pending.size() == 0) begin
                report_mismatch("result with no transaction pending", 0, got.cls);
                return;
            end
            exp_rec = pending.pop_front();
            checked++;
            if (got.cls != exp_rec.cls) report_mismatch("instr_class", exp_rec.cls, got.cls);
            if (got.cond != exp_rec.cond) report_mismatch("cond_code", exp_rec.cond, got.cond);
            if (got.rd != exp_rec.rd) report_mismatch("dest_reg", exp_rec.rd, got.rd);
            if (got.rn != exp_rec.rn) report_mismatch("base_reg", exp_rec.rn, got.rn);
            if (got.rm != exp_rec.rm) report_mismatch("operand_reg", exp_rec.rm, got.rm);
            if (got.rs != exp_rec.rs) report_mismatch("second_reg", exp_rec.rs, got.rs);
            if (got.imm != exp_rec.imm) report_mismatch("imm_value", exp_rec.imm, got.imm);
            if (got.target != exp_rec.target)
                report_mismatch("jump_target", exp_rec.target, got.target);
            if (got.flow != exp_rec.flow) report_mismatch("flow_flags", exp_rec.flow, got.flow);
            if (got.mode != exp_rec.mode) report_mismatch("mode_flags", exp_rec.mode, got.mode);
            if (got.shift != exp_rec.shift)
                report_mismatch("shift_info", exp_rec.shift, got.shift);
            if (got.extra != exp_rec.extra)
                report_mismatch("extra_bundle", exp_rec.extra, got.extra);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [31:0]        instr_word = '0;
    logic [31:0]        instr_address = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [5:0]         instr_class;
    logic [3:0]         cond_code;
    logic [3:0]         dest_reg;
    logic [3:0]         base_reg;
    logic [3:0]         operand_reg;
    logic [3:0]         second_reg;
    logic signed [31:0] imm_value;
    logic [31:0]        jump_target;
    logic [4:0]         flow_flags;
    logic [7:0]         mode_flags;
    logic [6:0]         shift_info;
    logic [19:0]        extra_bundle;

    decode_scoreboard decode_board = new();
    int  send_idle_pct;
    int  stall_pct;
    longint cycle_count;
    int  words_sent;
    int  class_seen[64];

    arm32_instruction_decoder u_top (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        a32dec_pkg::rec_t got;
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
            decode_board.note_word(instr_word, instr_address);
        if (rst_n && out_valid && out_ready) begin
            got = '{instr_class, cond_code, dest_reg, base_reg, operand_reg, second_reg,
                    imm_value, jump_target, flow_flags, mode_flags, shift_info,
                    extra_bundle};
            class_seen[instr_class]++;
            decode_board.check_record(got);
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_word(logic [31:0] w, logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        instr_word <= w;
        instr_address <= addr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (decode_board.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] shaped_word();
        logic [31:0] w;
        logic [31:0] r;
        w = $urandom();
        r = $urandom_range(0, 19);
        case (r)
            0: w = (w & 32'h0FFFFFF0) == 0 ? w : (w & 32'hF000000F) | 32'h012FFF10;
            1: w = (w & 32'hF000000F) | 32'h012FFF30;
            2: w = (w & 32'hF000F00F) | 32'h016F0F10;
            3: w = (w & 32'hF00FFF0F) | 32'hE1200070 & 32'hFFF000F0 | (w & 32'h000FFF0F);
            4: w = (w & 32'hF040F000) | 32'h010F0000;
            5: w = (w & 32'hF04F000F) | 32'h0120F000 | (w & 32'h00000FF0);
            6: w = (w & 32'hF04F0FFF) | 32'h0320F000;
            7: w = (w & 32'hF0FFFFEF) | 32'h0E000010;
            8: w = (w & 32'hF0FFFF0F) | 32'h00000090;
            9: w = (w & 32'hF1FFFF6F) | 32'h00000090 | ($urandom_range(1, 3) << 5);
            10: w = (w & 32'hF1FFFFFF) | 32'h08000000;
            11: w = (w & 32'h0FFFFFFF) | 32'hFA000000 & 32'hFE000000 | (w & 32'h01FFFFFF);
            12: w = (w & 32'hF1FFFFFF) | 32'h0A000000;
            13: w = (w & 32'hF3FFFFFF) | 32'h04000000;
            14: w = (w & 32'hFFF000F0) | 32'h01200070 | (w & 32'h000FFF0F);
            15: w = (w & 32'h0FFFFFFF) | 32'hE0000000;
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        int phase;
        directed = '{32'hEAFFFFFE, 32'h0A7FFFFF, 32'hEB800000, 32'hFB000001, 32'hFAFFFFFF,
                     32'hE1A0F00E, 32'hE08FF002, 32'hE3B00000 | 32'hFFF, 32'hE0110312,
                     32'hE59FF004, 32'hE51DE3FF, 32'hE7D21463, 32'hE1D120F0,
                     32'hE05120DF, 32'hE0000B93, 32'hE0F43291, 32'hE8BD8000,
                     32'hE92D4010, 32'hE12FFF1E, 32'hE12FFF33, 32'hE16F1F12,
                     32'hEFFFFFFF, 32'hE12FFF7F, 32'hE14F2000, 32'hE369F4FF,
                     32'hEE1F0F1F, 32'hE1200071, 32'h00000000, 32'hFFFFFFFF};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 0;
        stall_pct = 0;
        foreach (directed[k])
            send_word(directed[k], (k == 0) ? 32'hFFFFFFF8 : $urandom());
        drain_results();
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 25 : 51) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 25 : 51) : 0;
            repeat (450) send_word(shaped_word(), $urandom());
            drain_results();
        end
        $display("sent %0d instruction words over four idle/stall mixes; %0d results checked",
                 words_sent, decode_board.checked);
        if (decode_board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/a32dec_pkg.sv
rtl/core/a32dec_logic.sv
rtl/core/arm32_instruction_decoder.sv
test/arm32_instruction_decoder_tb.sv
